### src/lpfr_pkg.sv
// Shared constants for the length-prefixed frame receiver.
package lpfr_pkg;

    // Width of one link byte and of the stored payload entries.
    localparam int BYTE_W = 8;

    // Width of the announced length and of the received byte count.
    localparam int LEN_W = 16;

    // Width of the kept-length register and of the delivered frame length.
    localparam int KEEP_W = 7;

    // Byte that opens every frame.
    localparam logic [BYTE_W-1:0] START_MARK = 8'h3C;

    // Reset value of the kept-length register.
    localparam logic [KEEP_W-1:0] MAX_PAYLOAD_RST = 7'd64;

    // Default number of entries in the payload store.
    localparam int STORE_DEPTH_DEF = 64;

endpackage

### src/lpfr_store.sv
// Payload store: one write port and one registered read port.
module lpfr_store #(
    parameter int STORE_DEPTH = lpfr_pkg::STORE_DEPTH_DEF,
    parameter int ADDR_W      = 6
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [lpfr_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [lpfr_pkg::BYTE_W-1:0] o_rd_data
);
    import lpfr_pkg::*;

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/length_prefixed_frame_receiver.sv
// A completed frame's words pass the store's read register, then the output register.
// Throughput: one input byte per cycle while parsing; the drain issues the next store read
// only once the previous read's word has returned and the output register can take it.
// Input is held off (o_s_tready low) while reads of a completed frame are issued.
// Reset (i_rst_n low at a clock edge) returns to hunting, empties the output
// register and sets the kept length to 64; the store contents are left as they are.
module length_prefixed_frame_receiver #(
    parameter int STORE_DEPTH = lpfr_pkg::STORE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: max_payload.
    input  logic                        i_cfg_we,
    input  logic [lpfr_pkg::KEEP_W-1:0] i_cfg_wdata,
    // Input stream.
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,  // [7:0] rx_byte
    // Output stream.
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [15:0]                 o_m_tdata,  // [7:0] out_byte, [14:8] out_frame_length
    output logic                        o_m_tlast   // out_last
);
    import lpfr_pkg::*;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [KEEP_W-1:0] DEPTH_K = KEEP_W'(STORE_DEPTH);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_MARK,
        ST_LEN_LO,
        ST_PAYLOAD,
        ST_DRAIN
    } t_state;

    t_state              r_state;
    logic [KEEP_W-1:0]   r_max_payload;
    logic [LEN_W-1:0]    r_ann_len;
    logic [LEN_W-1:0]    r_rcv_cnt;
    logic [KEEP_W-1:0]   r_frame_n;
    logic [KEEP_W-1:0]   r_rd_idx;
    logic                r_rd_pend;
    logic                r_rd_last;
    logic                r_out_valid;
    logic                r_out_last;
    logic [BYTE_W-1:0]   r_out_byte;
    logic [KEEP_W-1:0]   r_out_len;

    logic                in_acc;
    logic [KEEP_W-1:0]   lim;
    logic [LEN_W-1:0]    n_rcv_cnt;
    logic                keep_byte;
    logic                frame_done;
    logic [KEEP_W-1:0]   n_frame_n;
    logic                rd_issue;
    logic                rd_is_last;
    logic [BYTE_W-1:0]   rd_data;

    // The kept length never exceeds the store depth.
    assign lim = (r_max_payload > DEPTH_K) ? DEPTH_K : r_max_payload;

    assign o_s_tready = (r_state != ST_DRAIN);
    assign in_acc     = i_s_tvalid && o_s_tready;

    // Payload byte bookkeeping.
    assign n_rcv_cnt  = r_rcv_cnt + LEN_W'(1);
    assign keep_byte  = in_acc && (r_state == ST_PAYLOAD)
                        && (r_rcv_cnt < {{(LEN_W-KEEP_W){1'b0}}, lim});
    assign frame_done = in_acc && (r_state == ST_PAYLOAD) && (n_rcv_cnt >= r_ann_len);
    assign n_frame_n  = (r_ann_len < {{(LEN_W-KEEP_W){1'b0}}, lim})
                        ? r_ann_len[KEEP_W-1:0] : lim;

    // A read is issued only when its word can be loaded into the output register.
    assign rd_issue   = (r_state == ST_DRAIN) && !r_rd_pend
                        && (!r_out_valid || i_m_tready) && (r_rd_idx < r_frame_n);
    assign rd_is_last = ((r_rd_idx + KEEP_W'(1)) == r_frame_n);

    lpfr_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (keep_byte),
        .i_wr_addr (r_rcv_cnt[ADDR_W-1:0]),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_rd_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Parser, drain sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_HUNT;
            r_max_payload <= MAX_PAYLOAD_RST;
            r_ann_len     <= '0;
            r_rcv_cnt     <= '0;
            r_frame_n     <= '0;
            r_rd_idx      <= '0;
            r_rd_pend     <= 1'b0;
            r_rd_last     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_wdata;
            end

            unique case (r_state)
                ST_HUNT: begin
                    if (in_acc && (i_s_tdata == START_MARK)) begin
                        r_state <= ST_MARK;
                    end
                end
                ST_MARK: begin
                    if (in_acc) begin
                        r_ann_len <= {{(LEN_W-BYTE_W){1'b0}}, i_s_tdata};
                        r_state   <= ST_LEN_LO;
                    end
                end
                ST_LEN_LO: begin
                    if (in_acc) begin
                        r_ann_len <= {i_s_tdata, r_ann_len[BYTE_W-1:0]};
                        r_rcv_cnt <= '0;
                        if ({i_s_tdata, r_ann_len[BYTE_W-1:0]} != '0) begin
                            r_state <= ST_PAYLOAD;
                        end else begin
                            r_state <= ST_HUNT;
                        end
                    end
                end
                ST_PAYLOAD: begin
                    if (in_acc) begin
                        r_rcv_cnt <= n_rcv_cnt;
                    end
                    if (frame_done) begin
                        r_frame_n <= n_frame_n;
                        r_rd_idx  <= '0;
                        if (n_frame_n != '0) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_state <= ST_HUNT;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (rd_issue) begin
                        r_rd_idx <= r_rd_idx + KEEP_W'(1);
                        if (rd_is_last) begin
                            r_state <= ST_HUNT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_HUNT;
                end
            endcase

            // Read data arrives in the cycle after the read was issued.
            r_rd_pend <= rd_issue;
            if (rd_issue) begin
                r_rd_last <= rd_is_last;
            end

            // The output register loads a returning word or empties when taken.
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_out_byte <= rd_data;
            r_out_last <= r_rd_last;
            r_out_len  <= r_frame_n;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_len, r_out_byte};
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    // A returning read word always finds the output register free.
    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (!r_out_valid || i_m_tready))
        else $error("read data would overwrite an untaken output word");

    // Reads of the store are issued only while input is held off.
    a_no_input_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |-> !o_s_tready)
        else $error("store read issued while input is accepted");

    // Writes stay within the store depth.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        keep_byte |-> (r_rcv_cnt < {{(LEN_W-KEEP_W){1'b0}}, DEPTH_K}))
        else $error("store write beyond its depth");

    // The last word of a frame is followed by no further read of that frame.
    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_issue && rd_is_last) |=> (r_state != ST_DRAIN))
        else $error("drain continued after the final read");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for the length-prefixed frame receiver.
`timescale 1ns / 1ps

module testbench;
    import lpfr_pkg::*;

    localparam int STORE_DEPTH = STORE_DEPTH_DEF;
    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    // Cycles allowed after the last word for the block to settle (read pipeline).
    localparam int DRAIN_GUARD = 10;
    localparam int CYCLE_LIMIT = 300000;

    typedef enum logic [1:0] {
        PS_HUNT    = 2'd0,
        PS_MARK    = 2'd1,
        PS_LEN_LO  = 2'd2,
        PS_PAYLOAD = 2'd3
    } t_parse_state;

    // One delivered payload word as the output stream should carry it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [KEEP_W-1:0] flen;
    } t_rx_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [KEEP_W-1:0]   i_cfg_wdata = '0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [15:0]         o_m_tdata;
    logic                o_m_tlast;

    length_prefixed_frame_receiver #(
        .STORE_DEPTH(STORE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Link bytes still to be sent and words still to be delivered.
    logic [7:0]   rx_pending[$];
    t_rx_word     expected_words[$];
    int           bytes_queued = 0;
    int           fail_count = 0;
    int           cycle_count = 0;

    // Mirror of the receiver state.
    logic [KEEP_W-1:0] keep_max = MAX_PAYLOAD_RST;
    t_parse_state      parse_st = PS_HUNT;
    logic [LEN_W-1:0]  ann_len = '0;
    logic [LEN_W-1:0]  rx_cnt = '0;
    logic [7:0]        store_copy[STORE_DEPTH];

    // Handshake flags seen at the last rising edge.
    logic rx_taken = 1'b0;
    logic tx_taken = 1'b0;

    int rx_gap = 0;
    int rx_calm = 0;
    int tx_hold = 0;
    int tx_calm = 0;

    // Wait drawn per byte or word: usually random, with stretches of no waiting.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(4, 30);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Advance the mirrored parser by one link byte and queue the words it completes.
    function automatic void predict_rx_byte(input logic [7:0] b);
        int lim;
        int n;
        t_rx_word w;
        lim = (keep_max > STORE_DEPTH) ? STORE_DEPTH : keep_max;
        case (parse_st)
            PS_HUNT: begin
                if (b == START_MARK) parse_st = PS_MARK;
            end
            PS_MARK: begin
                ann_len = {8'h00, b};
                parse_st = PS_LEN_LO;
            end
            PS_LEN_LO: begin
                ann_len[15:8] = b;
                rx_cnt = '0;
                parse_st = (ann_len != 0) ? PS_PAYLOAD : PS_HUNT;
            end
            default: begin
                if (rx_cnt < lim) store_copy[rx_cnt[IDX_W-1:0]] = b;
                rx_cnt = rx_cnt + 1'b1;
                if (rx_cnt >= ann_len) begin
                    parse_st = PS_HUNT;
                    n = (ann_len < lim) ? ann_len : lim;
                    for (int k = 0; k < n; k++) begin
                        w.data = store_copy[k[IDX_W-1:0]];
                        w.last = (k + 1 == n);
                        w.flen = n[KEEP_W-1:0];
                        expected_words.push_back(w);
                    end
                end
            end
        endcase
    endfunction

    // Input driver: presents queued bytes with random gaps between them.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || rx_taken)) begin
            if (rx_gap > 0) begin
                rx_gap--;
                i_s_tvalid <= 1'b0;
            end else if (rx_pending.size() != 0) begin
                i_s_tdata  <= rx_pending.pop_front();
                i_s_tvalid <= 1'b1;
                rx_gap = draw_wait(rx_calm);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: stalls for a random number of cycles after each word.
    always @(negedge i_clk) begin
        if (tx_taken) begin
            tx_hold = draw_wait(tx_calm);
        end else if (tx_hold > 0) begin
            tx_hold--;
        end
        i_m_tready <= (tx_hold == 0);
    end

    // Monitor: track accepted bytes and config writes, check delivered words.
    always @(posedge i_clk) begin
        t_rx_word w;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        rx_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        tx_taken <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: out_byte %02h out_frame_length %0d out_last %0b",
                           o_m_tdata[7:0], o_m_tdata[14:8], o_m_tlast);
                    fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    if (o_m_tdata[7:0] !== w.data) begin
                        $error("out_byte: expected %02h, got %02h", w.data, o_m_tdata[7:0]);
                        fail_count++;
                    end
                    if (o_m_tdata[14:8] !== w.flen) begin
                        $error("out_frame_length: expected %0d, got %0d",
                               w.flen, o_m_tdata[14:8]);
                        fail_count++;
                    end
                    if (o_m_tlast !== w.last) begin
                        $error("out_last: expected %0b, got %0b", w.last, o_m_tlast);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) predict_rx_byte(i_s_tdata);
            if (i_cfg_we) keep_max = i_cfg_wdata;
        end
    end

    // Wait until every byte is sent and every word delivered, then let the block settle.
    task automatic wait_idle();
        while (rx_pending.size() != 0 || i_s_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GUARD) @(posedge i_clk);
    endtask

    task automatic write_keep_max(input logic [KEEP_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    // Bytes seen while hunting; never the start marker.
    task automatic queue_noise(input int count);
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == START_MARK) b = ~b;
            queue_byte(b);
        end
    endtask

    // A whole frame with random payload; nested puts a header lookalike at its start.
    task automatic queue_frame(input int len, input bit nested);
        logic [15:0] l;
        l = len[15:0];
        queue_byte(START_MARK);
        queue_byte(l[7:0]);
        queue_byte(l[15:8]);
        for (int k = 0; k < len; k++) begin
            if (nested && k == 0)
                queue_byte(START_MARK);
            else if (nested && k < 3)
                queue_byte(8'($urandom_range(0, 3)));
            else if ($urandom_range(0, 7) == 0)
                queue_byte(START_MARK);
            else
                queue_byte(8'($urandom_range(0, 255)));
        end
    endtask

    localparam logic [KEEP_W-1:0] KEEP_SET[8] =
        '{7'd64, 7'd127, 7'd1, 7'd0, 7'd65, 7'd8, 7'd100, 7'd33};

    initial begin
        int eff;
        int len;
        int sel;
        int r;
        int target;
        logic [KEEP_W-1:0] v;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: noise, a zero-length frame, and a first frame at the reset maximum.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(START_MARK); queue_byte(8'h00); queue_byte(8'h00);
        queue_byte(START_MARK); queue_byte(8'h04); queue_byte(8'h00);
        queue_byte(8'h00); queue_byte(8'hFF); queue_byte(START_MARK); queue_byte(8'hA5);
        wait_idle();

        // Maximum of one: a three-byte frame delivers a single word.
        write_keep_max(7'd1);
        queue_byte(START_MARK); queue_byte(8'h03); queue_byte(8'h00);
        queue_byte(8'h5A); queue_byte(8'hC3); queue_byte(8'h7E);
        wait_idle();

        // Maximum of zero: the frame completes with no word.
        write_keep_max(7'd0);
        queue_byte(START_MARK); queue_byte(8'h02); queue_byte(8'h00);
        queue_byte(8'h11); queue_byte(8'h22);
        wait_idle();

        // Maximum raised mid-frame: entry 2 keeps what the first frame stored there.
        write_keep_max(7'd2);
        queue_byte(START_MARK); queue_byte(8'h06); queue_byte(8'h00);
        queue_byte(8'h81); queue_byte(8'h42); queue_byte(8'h24);
        wait_idle();
        write_keep_max(7'd64);
        queue_byte(8'h18); queue_byte(8'h99); queue_byte(8'hE7);
        wait_idle();

        // Random phases, each at its own maximum; every phase ends between frames.
        for (int p = 0; p < 8; p++) begin
            v = (p == 7) ? KEEP_W'($urandom_range(1, 64)) : KEEP_SET[p];
            write_keep_max(v);
            eff = (v > STORE_DEPTH) ? STORE_DEPTH : v;
            target = bytes_queued + 6;
            while (bytes_queued < target) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    queue_noise($urandom_range(1, 4));
                end else if (sel == 1) begin
                    queue_frame(0, 1'b0);
                end else begin
                    r = $urandom_range(0, 9);
                    if (r < 8)
                        len = $urandom_range(1, 6);
                    else if (eff < 10)
                        len = eff + $urandom_range(0, 2) - 1;
                    else
                        len = $urandom_range(7, 10);
                    if (len < 1) len = 1;
                    queue_frame(len, sel == 2);
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
